[rtl/p80d_pkg.sv]
package p80d_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 8'd1;

    // Round counter
    localparam int unsigned CNT_W = 5;
    localparam logic [CNT_W-1:0] CNT_FIRST = 5'd1;
    localparam logic [CNT_W-1:0] CNT_LAST  = 5'd31;

    localparam int unsigned KEY_W   = 80;
    localparam int unsigned BLOCK_W = 64;

    typedef struct packed {
        logic [BLOCK_W-1:0] ciphertext;
        logic               last_block;
    } t_in_item;

    typedef struct packed {
        logic [BLOCK_W-1:0] plaintext;
        logic               last_out;
    } t_out_item;

    // Control for the shared round unit
    typedef struct packed {
        logic             fwd_key;
        logic [CNT_W-1:0] ctr;
    } t_rnd_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_KEYGEN,
        ST_ROUND,
        ST_FINAL
    } t_state;

    function automatic logic [3:0] fwd_sbox(input logic [3:0] x);
        logic [3:0] y;
        case (x)
            4'h0: y = 4'hC;
            4'h1: y = 4'h5;
            4'h2: y = 4'h6;
            4'h3: y = 4'hB;
            4'h4: y = 4'h9;
            4'h5: y = 4'h0;
            4'h6: y = 4'hA;
            4'h7: y = 4'hD;
            4'h8: y = 4'h3;
            4'h9: y = 4'hE;
            4'hA: y = 4'hF;
            4'hB: y = 4'h8;
            4'hC: y = 4'h4;
            4'hD: y = 4'h7;
            4'hE: y = 4'h1;
            default: y = 4'h2;
        endcase
        return y;
    endfunction

    function automatic logic [3:0] inv_sbox(input logic [3:0] x);
        logic [3:0] y;
        case (x)
            4'h0: y = 4'h5;
            4'h1: y = 4'hE;
            4'h2: y = 4'hF;
            4'h3: y = 4'h8;
            4'h4: y = 4'hC;
            4'h5: y = 4'h1;
            4'h6: y = 4'h2;
            4'h7: y = 4'hD;
            4'h8: y = 4'hB;
            4'h9: y = 4'h4;
            4'hA: y = 4'h6;
            4'hB: y = 4'h3;
            4'hC: y = 4'h0;
            4'hD: y = 4'h7;
            4'hE: y = 4'h9;
            default: y = 4'hA;
        endcase
        return y;
    endfunction

    // Inverse bit permutation: bit k goes to 4k mod 63, bit 63 stays put
    function automatic logic [BLOCK_W-1:0] inv_perm(input logic [BLOCK_W-1:0] s);
        logic [BLOCK_W-1:0] t;
        t = '0;
        for (int k = 0; k < BLOCK_W - 1; k++) begin
            t[(4 * k) % (BLOCK_W - 1)] = s[k];
        end
        t[BLOCK_W-1] = s[BLOCK_W-1];
        return t;
    endfunction

    function automatic logic [BLOCK_W-1:0] inv_sub(input logic [BLOCK_W-1:0] s);
        logic [BLOCK_W-1:0] t;
        for (int n = 0; n < BLOCK_W / 4; n++) begin
            t[4*n +: 4] = inv_sbox(s[4*n +: 4]);
        end
        return t;
    endfunction

endpackage

[rtl/p80d_round.sv]
module p80d_round (
    input  logic [p80d_pkg::BLOCK_W-1:0] i_state,
    input  logic [p80d_pkg::KEY_W-1:0]   i_key,
    input  p80d_pkg::t_rnd_ctl           i_ctl,
    output logic [p80d_pkg::BLOCK_W-1:0] o_state,
    output logic [p80d_pkg::KEY_W-1:0]   o_key
);

    logic [p80d_pkg::KEY_W-1:0] w_fwd_rot;
    logic [p80d_pkg::KEY_W-1:0] w_fwd_key;
    logic [p80d_pkg::KEY_W-1:0] w_inv_tmp;
    logic [p80d_pkg::KEY_W-1:0] w_inv_key;

    // One decryption round: add round key, inverse permutation, inverse S-box
    assign o_state = p80d_pkg::inv_sub(p80d_pkg::inv_perm(
                         i_state ^ i_key[p80d_pkg::KEY_W-1 -: p80d_pkg::BLOCK_W]));

    // Forward key step: rotate left 61, S-box top nibble, add counter at bits 19..15
    always_comb begin
        w_fwd_rot = {i_key[18:0], i_key[79:19]};
        w_fwd_key = w_fwd_rot;
        w_fwd_key[79:76] = p80d_pkg::fwd_sbox(w_fwd_rot[79:76]);
        w_fwd_key[19:15] = w_fwd_rot[19:15] ^ i_ctl.ctr;
    end

    // Inverse key step: remove counter, inverse S-box top nibble, rotate left 19
    always_comb begin
        w_inv_tmp = i_key;
        w_inv_tmp[19:15] = i_key[19:15] ^ i_ctl.ctr;
        w_inv_tmp[79:76] = p80d_pkg::inv_sbox(i_key[79:76]);
        w_inv_key = {w_inv_tmp[60:0], w_inv_tmp[79:61]};
    end

    assign o_key = i_ctl.fwd_key ? w_fwd_key : w_inv_key;

endmodule

[rtl/present80_block_decrypt.sv]
// Channel  | Direction | Handshake                  | Payload
// request  | in        | start, busy                | i_in_item (ciphertext, last_block)
// result   | out       | o_strobe (one cycle)       | o_out_item (plaintext, last_out)
// config   | in        | i_cfg_valid, o_cfg_ready   | i_cfg_index, i_cfg_data
//
// A request passes through the shared round unit for the 31 inverse rounds
// and then a key whitening step; the result strobes in the cycle busy falls.
// The first request after reset or after a key write first runs the key
// schedule forward through the same unit to find the last round key; it is
// kept until the key changes. Reset is synchronous, active low. The result
// cannot be stalled; config is always ready.
module present80_block_decrypt (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  p80d_pkg::t_in_item                i_in_item,
    output logic                              o_strobe,
    output p80d_pkg::t_out_item               o_out_item,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [p80d_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [p80d_pkg::BLOCK_W-1:0]      i_cfg_data
);

    p80d_pkg::t_state                   r_state, n_state;
    logic [p80d_pkg::CNT_W-1:0]         r_cnt, n_cnt;
    logic [p80d_pkg::BLOCK_W-1:0]       r_s, n_s;
    logic [p80d_pkg::KEY_W-1:0]         r_key, n_key;
    logic [p80d_pkg::KEY_W-1:0]         r_key_end, n_key_end;
    logic                               r_dirty, n_dirty;
    logic                               r_last, n_last;
    logic [p80d_pkg::BLOCK_W-1:0]       r_key_high;
    logic [15:0]                        r_key_low;
    logic                               r_strobe, n_strobe;
    p80d_pkg::t_out_item                r_out, n_out;

    p80d_pkg::t_rnd_ctl                 w_ctl;
    logic [p80d_pkg::BLOCK_W-1:0]       w_s_next;
    logic [p80d_pkg::KEY_W-1:0]         w_key_next;
    logic                               w_cfg_wr;
    logic                               w_accept;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;
    assign busy        = (r_state != p80d_pkg::ST_IDLE);
    assign w_accept    = start && !busy;
    assign o_strobe    = r_strobe;
    assign o_out_item  = r_out;

    p80d_round u_round (
        .i_state (r_s),
        .i_key   (r_key),
        .i_ctl   (w_ctl),
        .o_state (w_s_next),
        .o_key   (w_key_next)
    );

    // Hold the key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (w_cfg_wr) begin
            unique case (i_cfg_index)
                p80d_pkg::CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                p80d_pkg::CFG_KEY_LOW:  r_key_low  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= p80d_pkg::ST_IDLE;
            r_dirty  <= 1'b1;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_dirty  <= n_dirty;
            r_strobe <= n_strobe;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_cnt     <= n_cnt;
        r_s       <= n_s;
        r_key     <= n_key;
        r_key_end <= n_key_end;
        r_last    <= n_last;
        r_out     <= n_out;
    end

    // Next state and datapath control
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_s       = r_s;
        n_key     = r_key;
        n_key_end = r_key_end;
        n_dirty   = r_dirty;
        n_last    = r_last;
        n_strobe  = 1'b0;
        n_out     = r_out;
        w_ctl.fwd_key = 1'b0;
        w_ctl.ctr     = r_cnt;

        unique case (r_state)
            p80d_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_s    = i_in_item.ciphertext;
                    n_last = i_in_item.last_block;
                    if (r_dirty) begin
                        // key changed: run the schedule forward first
                        n_key   = {r_key_high, r_key_low};
                        n_cnt   = p80d_pkg::CNT_FIRST;
                        n_dirty = 1'b0;
                        n_state = p80d_pkg::ST_KEYGEN;
                    end else begin
                        n_key   = r_key_end;
                        n_cnt   = p80d_pkg::CNT_LAST;
                        n_state = p80d_pkg::ST_ROUND;
                    end
                end
            end
            p80d_pkg::ST_KEYGEN: begin
                w_ctl.fwd_key = 1'b1;
                n_key = w_key_next;
                if (r_cnt == p80d_pkg::CNT_LAST) begin
                    n_key_end = w_key_next;
                    n_cnt     = p80d_pkg::CNT_LAST;
                    n_state   = p80d_pkg::ST_ROUND;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            p80d_pkg::ST_ROUND: begin
                // advance one round and step the key back
                n_s   = w_s_next;
                n_key = w_key_next;
                if (r_cnt == p80d_pkg::CNT_FIRST) begin
                    n_state = p80d_pkg::ST_FINAL;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            p80d_pkg::ST_FINAL: begin
                // whiten with the first round key and present the result
                n_out.plaintext = r_s ^ r_key[p80d_pkg::KEY_W-1 -: p80d_pkg::BLOCK_W];
                n_out.last_out  = r_last;
                n_strobe        = 1'b1;
                n_state         = p80d_pkg::ST_IDLE;
            end
            default: n_state = p80d_pkg::ST_IDLE;
        endcase

        // Mark the cached last round key stale on any key write
        if (w_cfg_wr && (i_cfg_index == p80d_pkg::CFG_KEY_HIGH
                         || i_cfg_index == p80d_pkg::CFG_KEY_LOW)) begin
            n_dirty = 1'b1;
        end
    end

endmodule

[tb/present80_block_decrypt_checker.sv]
`timescale 1ns / 1ps

// Watches the request, result and config channels of the decryptor, predicts
// each plaintext from the key held at the time of the request and compares.
module present80_block_decrypt_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_busy,
    input  p80d_pkg::t_in_item             i_in_item,
    input  logic                           i_strobe,
    input  p80d_pkg::t_out_item            i_out_item,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [p80d_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [p80d_pkg::BLOCK_W-1:0]   i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);

    // S-box tables, entry n in nibble n
    localparam logic [63:0] SBOX_FWD   = 64'h2174_8FE3_DA09_B65C;
    localparam logic [63:0] SBOX_INV   = 64'hA970_364B_D21C_8FE5;
    localparam int          NUM_RKEYS  = 32;
    localparam int          MAX_REPORT = 200;

    logic [63:0]         key_hi;
    logic [15:0]         key_lo;
    p80d_pkg::t_out_item plain_q[$];
    p80d_pkg::t_out_item want_item;
    p80d_pkg::t_out_item got_item;
    int                  fail_cnt = 0;

    assign o_fail_count = fail_cnt;

    // Output bit j of the inverse permutation takes input bit 16j mod 63
    function automatic logic [63:0] unshuffle_bits(input logic [63:0] s);
        logic [63:0] t;
        for (int j = 0; j < 63; j++) begin
            t[j] = s[(16 * j) % 63];
        end
        t[63] = s[63];
        return t;
    endfunction

    function automatic logic [63:0] unsub_nibbles(input logic [63:0] s);
        logic [63:0] t;
        int          idx;
        for (int n = 0; n < 16; n++) begin
            idx = int'(s[4*n +: 4]);
            t[4*n +: 4] = SBOX_INV[4*idx +: 4];
        end
        return t;
    endfunction

    // Full 80-bit schedule, then 31 inverse rounds and the closing whitening
    function automatic logic [63:0] decipher(input logic [63:0] text,
                                             input logic [63:0] kh,
                                             input logic [15:0] kl);
        logic [79:0] k;
        logic [63:0] rkey [0:NUM_RKEYS-1];
        logic [63:0] s;
        int          idx;
        k = {kh, kl};
        for (int r = 0; r < NUM_RKEYS; r++) begin
            rkey[r]   = k[79:16];
            k         = {k[18:0], k[79:19]};
            idx       = int'(k[79:76]);
            k[79:76]  = SBOX_FWD[4*idx +: 4];
            k[19:15]  = k[19:15] ^ 5'(r + 1);
        end
        s = text;
        for (int r = NUM_RKEYS - 1; r > 0; r--) begin
            s = unsub_nibbles(unshuffle_bits(s ^ rkey[r]));
        end
        return s ^ rkey[0];
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (fail_cnt < MAX_REPORT) begin
            $display("MISMATCH %s: got %h, wanted %h at %0t", what, got, want, $time);
        end
        fail_cnt++;
    endtask

    // Compare results first, then queue the request taken at the same edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            key_hi <= '0;
            key_lo <= '0;
            plain_q.delete();
            o_pending <= 0;
        end else begin
            if (i_strobe) begin
                got_item = i_out_item;
                if (plain_q.size() == 0) begin
                    report_mismatch("result with no request pending",
                                    got_item.plaintext, '0);
                end else begin
                    want_item = plain_q.pop_front();
                    if (got_item.plaintext !== want_item.plaintext) begin
                        report_mismatch("plaintext", got_item.plaintext,
                                        want_item.plaintext);
                    end
                    if (got_item.last_out !== want_item.last_out) begin
                        report_mismatch("last_out", 64'(got_item.last_out),
                                        64'(want_item.last_out));
                    end
                end
            end
            if (i_start && !i_busy) begin
                want_item.plaintext = decipher(i_in_item.ciphertext, key_hi, key_lo);
                want_item.last_out  = i_in_item.last_block;
                plain_q.push_back(want_item);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    p80d_pkg::CFG_KEY_HIGH: key_hi <= i_cfg_data;
                    p80d_pkg::CFG_KEY_LOW:  key_lo <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            o_pending <= plain_q.size();
        end
    end

endmodule

[tb/present80_block_decrypt_tb.sv]
`timescale 1ns / 1ps

module present80_block_decrypt_tb;

    localparam int NUM_PHASES      = 12;
    localparam int BLOCKS_PER_PH   = 125;
    localparam int SETTLE_CYCLES   = 80;
    localparam logic [p80d_pkg::CFG_IDX_W-1:0] CFG_IDX_TOP   = '1;
    localparam logic [p80d_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = p80d_pkg::CFG_KEY_LOW + 1'b1;

    logic                           clk;
    logic                           rst_n;
    logic                           start;
    logic                           busy;
    p80d_pkg::t_in_item             in_item;
    logic                           strobe;
    p80d_pkg::t_out_item            out_item;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [p80d_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [p80d_pkg::BLOCK_W-1:0]   cfg_data;
    int                             fail_count;
    int                             pending;

    present80_block_decrypt u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .start       (start),
        .busy        (busy),
        .i_in_item   (in_item),
        .o_strobe    (strobe),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    present80_block_decrypt_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_in_item    (in_item),
        .i_strobe     (strobe),
        .i_out_item   (out_item),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Present one request and hold it until the block takes it
    task automatic send_block(input logic [63:0] text, input logic last_flag);
        p80d_pkg::t_in_item item;
        item.ciphertext = text;
        item.last_block = last_flag;
        in_item <= item;
        start   <= 1'b1;
        do @(negedge clk); while (busy);
        @(posedge clk);
    endtask

    // Drop start, let the block finish, then idle for a burst
    task automatic pause_requests(input int cycles);
        start <= 1'b0;
        do @(negedge clk); while (busy);
        repeat (cycles) @(posedge clk);
    endtask

    // Drop start and wait until every result has come back
    task automatic drain_blocks();
        start <= 1'b0;
        do @(negedge clk); while (pending != 0 || busy);
        @(posedge clk);
        if ($urandom_range(0, 1) != 0) begin
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    // Write one register; keep valid high when another write follows
    task automatic cfg_write(input logic [p80d_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] data, input logic more);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        if (!more) begin
            cfg_valid <= 1'b0;
        end
    endtask

    // Mostly dense random blocks, some sparse and saturated patterns
    function automatic logic [63:0] pick_text();
        logic [63:0] v;
        case ($urandom_range(0, 9))
            0:       v = '0;
            1:       v = '1;
            2:       v = 64'd1 << $urandom_range(0, 63);
            3:       v = ~(64'd1 << $urandom_range(0, 63));
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    initial begin
        logic [63:0] kh;
        logic [63:0] kl;
        logic [31:0] pick_idx;
        logic [p80d_pkg::CFG_IDX_W-1:0] bad_idx;

        rst_n     <= 1'b0;
        start     <= 1'b0;
        in_item   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset key of all zeros
        send_block(64'h0, 1'b0);
        send_block(64'h5579_C138_7B22_8445, 1'b1);
        send_block(64'hA112_FFC7_2F68_417B, 1'b0);
        send_block('1, 1'b0);
        pause_requests(3);
        send_block(64'h1, 1'b1);

        // All-ones key; key_low data carries set high bits to be masked
        drain_blocks();
        cfg_write(p80d_pkg::CFG_KEY_HIGH, '1, 1'b1);
        cfg_write(p80d_pkg::CFG_KEY_LOW, '1, 1'b0);
        send_block(64'hE72C_46C0_F594_5049, 1'b0);
        send_block(64'h8000_0000_0000_0000, 1'b1);
        send_block(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        send_block(64'h5555_5555_5555_5555, 1'b1);

        // New key between blocks, with writes to unused indexes ignored
        drain_blocks();
        cfg_write(p80d_pkg::CFG_KEY_HIGH, 64'h0123_4567_89AB_CDEF, 1'b1);
        cfg_write(CFG_IDX_SPARE, {$urandom, $urandom}, 1'b1);
        cfg_write(CFG_IDX_TOP, {$urandom, $urandom}, 1'b0);
        send_block(64'h0, 1'b0);
        send_block('1, 1'b1);
        send_block(64'hFEDC_BA98_7654_3210, 1'b0);

        // Change only the low part of the key
        drain_blocks();
        cfg_write(p80d_pkg::CFG_KEY_LOW, 64'hFFFF_FFFF_FFFF_0000, 1'b0);
        send_block(64'h0, 1'b1);
        send_block('1, 1'b0);
        send_block(64'h0123_4567_89AB_CDEF, 1'b1);

        // Random phases, each under its own key; the last runs without gaps
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain_blocks();
            case (ph)
                0: begin
                    kh = '0;
                    kl = '0;
                end
                1: begin
                    kh = '1;
                    kl = '1;
                end
                default: begin
                    kh = {$urandom, $urandom};
                    kl = {$urandom, $urandom};
                end
            endcase
            if (ph < 2 || $urandom_range(0, 3) != 0) begin
                cfg_write(p80d_pkg::CFG_KEY_HIGH, kh, 1'b1);
            end
            if ($urandom_range(0, 3) == 0) begin
                pick_idx = $urandom_range(CFG_IDX_SPARE, CFG_IDX_TOP);
                bad_idx  = pick_idx[p80d_pkg::CFG_IDX_W-1:0];
                cfg_write(bad_idx, {$urandom, $urandom}, 1'b1);
            end
            cfg_write(p80d_pkg::CFG_KEY_LOW, kl, 1'b0);
            for (int i = 0; i < BLOCKS_PER_PH; i++) begin
                send_block(pick_text(), $urandom_range(0, 7) == 0);
                if (ph < NUM_PHASES - 1 && $urandom_range(0, 2) == 0) begin
                    pause_requests($urandom_range(1, 7));
                end
            end
        end

        drain_blocks();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
